/* hw/rtl/srpp_pkg.sv */
`default_nettype none

package srpp_pkg;

  localparam int KIND_W     = 3;
  localparam int DIST_W     = 24;
  localparam int SPEED_W    = 32;
  localparam int ACCEL_W    = 24;
  localparam int TICK_W     = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int TOTAL_W    = 23;
  localparam int TRAVEL_W   = 56;
  localparam int DRIVE_W    = 24;
  localparam int MUL_DIG    = 16;

  localparam logic [ACCEL_W-1:0] ACCEL_RESET = 24'd256;
  localparam logic [TICK_W-1:0]  TICK_RESET  = 20'd1000;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX   = '1;
  localparam logic [DRIVE_W-1:0] DRIVE_MAX   = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ACCEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE = 2'd1;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK     = 3'd0,
    KIND_START    = 3'd1,
    KIND_STOP     = 3'd2,
    KIND_MOVE     = 3'd3,
    KIND_SET_RATE = 3'd4,
    KIND_SET_DIR  = 3'd5
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_MUL_MT,
    S_REM,
    S_MUL_D,
    S_MUL_V,
    S_RAMP,
    S_TRAVEL,
    S_EMIT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CMD,
    OP_MUL_MT,
    OP_LOAD_REM,
    OP_MUL_D,
    OP_MUL_V,
    OP_BRAKE_IF,
    OP_BRAKE,
    OP_FINISH,
    OP_RAMP,
    OP_TRAVEL,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  run;
    logic  move;
    logic  mul_done;
    logic  rem_fin;
    logic  rem_le0;
    logic  out_block;
  } dp_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/srpp_mul.sv */
`default_nettype none

module srpp_mul import srpp_pkg::*; #(
  parameter int A_W = 64,
  parameter int B_W = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic               done,
  output logic [A_W+B_W-1:0] prod
);

  localparam int STEPS = (B_W + MUL_DIG - 1) / MUL_DIG;
  localparam int BP_W  = STEPS * MUL_DIG;
  localparam int P_W   = A_W + B_W;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [A_W-1:0]         a_r, a_nxt;
  logic [BP_W-1:0]        b_r, b_nxt;
  logic [P_W-1:0]         acc_r, acc_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [A_W+MUL_DIG-1:0] part;

  // One 16-bit digit of b per cycle, most significant digit first.
  assign part = a_r * b_r[BP_W-1 -: MUL_DIG];

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt    = a;
      b_nxt    = BP_W'(b);
      acc_nxt  = '0;
      cnt_nxt  = CNT_W'(STEPS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = {acc_r[P_W-MUL_DIG-1:0], {MUL_DIG{1'b0}}} + P_W'(part);
      b_nxt   = {b_r[BP_W-MUL_DIG-1:0], {MUL_DIG{1'b0}}};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

`default_nettype wire

/* hw/rtl/srpp_dp.sv */
`default_nettype none

module srpp_dp import srpp_pkg::*; #(
  parameter int FRAC_BITS  = 8,
  parameter int RATE_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_wdata,
  input  logic [KIND_W-1:0]         in_kind,
  input  logic signed [DIST_W-1:0]  in_move_distance,
  input  logic signed [SPEED_W-1:0] in_speed_value,
  input  logic                      in_dir_value,
  input  dp_cmd_t                   cmd,
  output dp_stat_t                  stat,
  input  logic                      out_stall,
  output logic                      out_valid,
  output logic [DRIVE_W-1:0]        out_step_freq_hz,
  output logic                      out_dir_out,
  output logic                      out_is_running,
  output logic                      out_in_move,
  output logic                      out_move_done
);

  localparam int RW      = RATE_WIDTH;
  localparam int SCALE_W = TICK_W + FRAC_BITS;
  localparam int PROD1_W = TOTAL_W + SCALE_W;
  localparam int REM_W   = ((PROD1_W > TRAVEL_W) ? PROD1_W : TRAVEL_W) + 2;
  localparam int MA_W0   = (SCALE_W > RW) ? SCALE_W : RW;
  localparam int MA_W    = (MA_W0 > REM_W - 1) ? MA_W0 : REM_W - 1;
  localparam int MB_W    = (RW > ACCEL_W + 1) ? RW : ACCEL_W + 1;
  localparam int P_W     = MA_W + MB_W;
  localparam int SX_W    = (RW > SPEED_W) ? RW : SPEED_W;
  localparam int AX_W    = ((RW > ACCEL_W) ? RW : ACCEL_W) + 2;
  localparam int TS_W    = TRAVEL_W + 1;
  localparam int DX_W    = RW + DRIVE_W;

  localparam logic signed [RW-1:0] RATE_MAX = {1'b0, {(RW-1){1'b1}}};
  localparam logic signed [RW-1:0] RATE_MIN = {1'b1, {(RW-1){1'b0}}};
  localparam logic signed [RW-1:0] HALF_HZ  = RW'(1) << (FRAC_BITS - 1);
  localparam logic signed [TRAVEL_W-1:0] TRAVEL_MAX = {1'b0, {(TRAVEL_W-1){1'b1}}};
  localparam logic signed [TRAVEL_W-1:0] TRAVEL_MIN = {1'b1, {(TRAVEL_W-1){1'b0}}};

  // Configuration registers.
  logic [ACCEL_W-1:0] max_accel_r, max_accel_nxt;
  logic [TICK_W-1:0]  tick_rate_r, tick_rate_nxt;

  // Captured command.
  kind_t                     kind_r, kind_nxt;
  logic signed [DIST_W-1:0]  dist_r, dist_nxt;
  logic signed [SPEED_W-1:0] speed_r, speed_nxt;
  logic                      dir_in_r, dir_in_nxt;

  // Profile state.
  logic                       run_r, run_nxt;
  logic                       move_r, move_nxt;
  logic                       dir_r, dir_nxt;
  logic signed [RW-1:0]       cur_r, cur_nxt;
  logic signed [RW-1:0]       tgt_r, tgt_nxt;
  logic [TOTAL_W-1:0]         total_r, total_nxt;
  logic signed [TRAVEL_W-1:0] travel_r, travel_nxt;
  logic [DRIVE_W-1:0]         drive_r, drive_nxt;
  logic                       done_r, done_nxt;

  // Braking test intermediates.
  logic signed [REM_W-1:0] rem_r, rem_nxt;
  logic [P_W-1:0]          d_r, d_nxt;

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  logic [DRIVE_W-1:0] out_freq_r, out_freq_nxt;
  logic               out_dir_r, out_dir_nxt;
  logic               out_run_r, out_run_nxt;
  logic               out_move_r, out_move_nxt;
  logic               out_done_r, out_done_nxt;

  // Shared multiplier.
  logic            mul_start;
  logic [MA_W-1:0] mul_a;
  logic [MB_W-1:0] mul_b;
  logic            mul_done;
  logic [P_W-1:0]  mul_prod;

  logic [TICK_W-1:0]        tick_eff;
  logic [SCALE_W-1:0]       scale;
  logic signed [SX_W-1:0]   spd_x;
  logic signed [RW-1:0]     spd_clamp;
  logic signed [AX_W-1:0]   acc_x;
  logic signed [RW-1:0]     start_rate;
  logic [DIST_W-1:0]        dist_mag;
  logic [TOTAL_W-1:0]       total_calc;
  logic signed [AX_W-1:0]   cur_x;
  logic signed [AX_W-1:0]   tgt_x;
  logic signed [AX_W-1:0]   diff;
  logic signed [RW-1:0]     ramp_rate;
  logic signed [TS_W-1:0]   tsum;
  logic signed [TRAVEL_W-1:0] travel_sat;
  logic [RW-1:0]            cur_u;
  logic [RW-1:0]            whole;
  logic [DX_W-1:0]          whole_x;
  logic [DRIVE_W-1:0]       drive_calc;
  logic [RW-1:0]            vmag;
  logic signed [REM_W-1:0]  rem_calc;
  logic signed [REM_W:0]    rem2;
  logic signed [REM_W:0]    scale2;
  logic                     out_take;

  srpp_mul #(
    .A_W (MA_W),
    .B_W (MB_W)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // A tick rate of zero counts as one tick per second.
  assign tick_eff = (tick_rate_r == '0) ? TICK_W'(1) : tick_rate_r;
  assign scale    = {tick_eff, {FRAC_BITS{1'b0}}};

  assign spd_x     = SX_W'(speed_r);
  assign spd_clamp = (spd_x > SX_W'(RATE_MAX)) ? RATE_MAX :
                     (spd_x < SX_W'(RATE_MIN)) ? RATE_MIN : RW'(spd_x);

  assign acc_x      = AX_W'($signed({1'b0, max_accel_r}));
  assign start_rate = (acc_x > AX_W'(RATE_MAX)) ? RATE_MAX : RW'(acc_x);

  assign dist_mag   = dist_r[DIST_W-1] ? (~dist_r + DIST_W'(1)) : dist_r;
  assign total_calc = dist_mag[DIST_W-1] ? TOTAL_MAX : dist_mag[TOTAL_W-1:0];

  // The step toward the target never passes it, so the result stays in range.
  assign cur_x = AX_W'(cur_r);
  assign tgt_x = AX_W'(tgt_r);
  assign diff  = tgt_x - cur_x;
  always_comb begin
    if (diff > acc_x) begin
      ramp_rate = RW'(cur_x + acc_x);
    end else if (diff < -acc_x) begin
      ramp_rate = RW'(cur_x - acc_x);
    end else begin
      ramp_rate = tgt_r;
    end
  end

  assign tsum = TS_W'(travel_r) + TS_W'(cur_r);
  assign travel_sat = (tsum[TS_W-1] != tsum[TS_W-2]) ?
                      (tsum[TS_W-1] ? TRAVEL_MIN : TRAVEL_MAX) : tsum[TRAVEL_W-1:0];

  assign cur_u      = cur_r;
  assign whole      = cur_u >> FRAC_BITS;
  assign whole_x    = DX_W'(whole);
  assign drive_calc = (cur_r <= HALF_HZ) ? '0 :
                      (whole_x > DX_W'(DRIVE_MAX)) ? DRIVE_MAX : whole_x[DRIVE_W-1:0];

  assign vmag = cur_r[RW-1] ? (~cur_u + RW'(1)) : cur_u;

  // Remaining distance in travel units: move_total * scale - travel_sum.
  assign rem_calc = REM_W'($signed({1'b0, mul_prod[PROD1_W-1:0]})) - REM_W'(travel_r);
  assign rem2     = {rem_r, 1'b0};
  assign scale2   = (REM_W+1)'(scale);

  assign out_take = out_valid_r && !out_stall;

  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (cmd.op)
      OP_MUL_MT: begin
        mul_start = 1'b1;
        mul_a     = MA_W'(scale);
        mul_b     = MB_W'(total_r);
      end
      OP_MUL_D: begin
        mul_start = 1'b1;
        mul_a     = MA_W'(rem_r[REM_W-2:0]);
        mul_b     = MB_W'({max_accel_r, 1'b0});
      end
      OP_MUL_V: begin
        mul_start = 1'b1;
        mul_a     = MA_W'(vmag);
        mul_b     = MB_W'(vmag);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    max_accel_nxt = max_accel_r;
    tick_rate_nxt = tick_rate_r;
    kind_nxt      = kind_r;
    dist_nxt      = dist_r;
    speed_nxt     = speed_r;
    dir_in_nxt    = dir_in_r;
    run_nxt       = run_r;
    move_nxt      = move_r;
    dir_nxt       = dir_r;
    cur_nxt       = cur_r;
    tgt_nxt       = tgt_r;
    total_nxt     = total_r;
    travel_nxt    = travel_r;
    drive_nxt     = drive_r;
    done_nxt      = done_r;
    rem_nxt       = rem_r;
    d_nxt         = d_r;
    out_valid_nxt = out_take ? 1'b0 : out_valid_r;
    out_freq_nxt  = out_freq_r;
    out_dir_nxt   = out_dir_r;
    out_run_nxt   = out_run_r;
    out_move_nxt  = out_move_r;
    out_done_nxt  = out_done_r;

    if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_ACCEL: max_accel_nxt = cfg_wdata[ACCEL_W-1:0];
        CFG_TICK_RATE: tick_rate_nxt = cfg_wdata[TICK_W-1:0];
        default: begin
        end
      endcase
    end

    case (cmd.op)
      OP_LOAD: begin
        kind_nxt   = kind_t'(in_kind);
        dist_nxt   = in_move_distance;
        speed_nxt  = in_speed_value;
        dir_in_nxt = in_dir_value;
        done_nxt   = 1'b0;
      end
      OP_CMD: begin
        case (kind_r)
          KIND_START: begin
            if (!run_r) begin
              cur_nxt    = start_rate;
              tgt_nxt    = start_rate;
              move_nxt   = 1'b0;
              travel_nxt = '0;
              run_nxt    = 1'b1;
            end
          end
          KIND_STOP: begin
            run_nxt    = 1'b0;
            move_nxt   = 1'b0;
            cur_nxt    = '0;
            tgt_nxt    = '0;
            travel_nxt = '0;
            drive_nxt  = '0;
          end
          KIND_MOVE: begin
            if (!run_r) begin
              cur_nxt = start_rate;
            end
            run_nxt    = 1'b1;
            move_nxt   = 1'b1;
            total_nxt  = total_calc;
            travel_nxt = '0;
            dir_nxt    = dist_r[DIST_W-1];
            tgt_nxt    = spd_clamp;
          end
          KIND_SET_RATE: tgt_nxt = spd_clamp;
          KIND_SET_DIR:  dir_nxt = dir_in_r;
          // A tick reaches here only while the controller is stopped.
          KIND_TICK: begin
            cur_nxt  = '0;
            move_nxt = 1'b0;
          end
          default: begin
          end
        endcase
      end
      OP_LOAD_REM: rem_nxt = rem_calc;
      OP_MUL_V:    d_nxt   = mul_prod;
      OP_BRAKE_IF: begin
        if (d_r <= mul_prod) begin
          tgt_nxt = '0;
        end
      end
      OP_BRAKE:    tgt_nxt = '0;
      OP_FINISH: begin
        cur_nxt   = '0;
        tgt_nxt   = '0;
        move_nxt  = 1'b0;
        drive_nxt = '0;
        done_nxt  = 1'b1;
      end
      OP_RAMP:     cur_nxt = ramp_rate;
      OP_TRAVEL: begin
        travel_nxt = travel_sat;
        drive_nxt  = drive_calc;
      end
      OP_EMIT: begin
        out_valid_nxt = 1'b1;
        out_freq_nxt  = drive_r;
        out_dir_nxt   = dir_r;
        out_run_nxt   = run_r;
        out_move_nxt  = move_r;
        out_done_nxt  = done_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_accel_r <= ACCEL_RESET;
      tick_rate_r <= TICK_RESET;
      run_r       <= 1'b0;
      move_r      <= 1'b0;
      dir_r       <= 1'b0;
      cur_r       <= '0;
      tgt_r       <= '0;
      total_r     <= '0;
      travel_r    <= '0;
      drive_r     <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      max_accel_r <= max_accel_nxt;
      tick_rate_r <= tick_rate_nxt;
      run_r       <= run_nxt;
      move_r      <= move_nxt;
      dir_r       <= dir_nxt;
      cur_r       <= cur_nxt;
      tgt_r       <= tgt_nxt;
      total_r     <= total_nxt;
      travel_r    <= travel_nxt;
      drive_r     <= drive_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    dist_r     <= dist_nxt;
    speed_r    <= speed_nxt;
    dir_in_r   <= dir_in_nxt;
    rem_r      <= rem_nxt;
    d_r        <= d_nxt;
    out_freq_r <= out_freq_nxt;
    out_dir_r  <= out_dir_nxt;
    out_run_r  <= out_run_nxt;
    out_move_r <= out_move_nxt;
    out_done_r <= out_done_nxt;
  end

  assign stat.kind      = kind_r;
  assign stat.run       = run_r;
  assign stat.move      = move_r;
  assign stat.mul_done  = mul_done;
  assign stat.rem_fin   = (rem2 <= scale2);
  assign stat.rem_le0   = rem_r[REM_W-1] || (rem_r == '0);
  assign stat.out_block = out_valid_r && out_stall;

  assign out_valid        = out_valid_r;
  assign out_step_freq_hz = out_freq_r;
  assign out_dir_out      = out_dir_r;
  assign out_is_running   = out_run_r;
  assign out_in_move      = out_move_r;
  assign out_move_done    = out_done_r;

endmodule

`default_nettype wire

/* hw/rtl/srpp_ctrl.sv */
`default_nettype none

module srpp_ctrl import srpp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.kind == KIND_TICK && stat.run) begin
          state_nxt = stat.move ? S_MUL_MT : S_RAMP;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_MUL_MT: begin
        if (stat.mul_done) begin
          state_nxt = S_REM;
        end
      end
      S_REM: begin
        if (stat.rem_fin) begin
          state_nxt = S_EMIT;
        end else if (stat.rem_le0) begin
          state_nxt = S_RAMP;
        end else begin
          state_nxt = S_MUL_D;
        end
      end
      S_MUL_D: begin
        if (stat.mul_done) begin
          state_nxt = S_MUL_V;
        end
      end
      S_MUL_V: begin
        if (stat.mul_done) begin
          state_nxt = S_RAMP;
        end
      end
      S_RAMP:   state_nxt = S_TRAVEL;
      S_TRAVEL: state_nxt = S_EMIT;
      S_EMIT: begin
        if (!stat.out_block) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op   = OP_NONE;
    in_stall = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_LOAD;
        end
      end
      S_EXEC: begin
        if (stat.kind == KIND_TICK && stat.run) begin
          cmd.op = stat.move ? OP_MUL_MT : OP_NONE;
        end else begin
          cmd.op = OP_CMD;
        end
      end
      S_MUL_MT: begin
        if (stat.mul_done) begin
          cmd.op = OP_LOAD_REM;
        end
      end
      // Completion wins over braking: it clears the target anyway.
      S_REM: begin
        if (stat.rem_fin) begin
          cmd.op = OP_FINISH;
        end else if (stat.rem_le0) begin
          cmd.op = OP_BRAKE;
        end else begin
          cmd.op = OP_MUL_D;
        end
      end
      S_MUL_D: begin
        if (stat.mul_done) begin
          cmd.op = OP_MUL_V;
        end
      end
      S_MUL_V: begin
        if (stat.mul_done) begin
          cmd.op = OP_BRAKE_IF;
        end
      end
      S_RAMP:   cmd.op = OP_RAMP;
      S_TRAVEL: cmd.op = OP_TRAVEL;
      S_EMIT: begin
        if (!stat.out_block) begin
          cmd.op = OP_EMIT;
        end
      end
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/stepper_ramp_position_profiler_core.sv */
// Stepper ramp position profiler: trapezoidal step-rate generator.
// Input channel (in_valid / in_stall): one command per transfer, either a
// control tick, start, stop, relative move, set target rate or set direction.
// Every command produces exactly one status transfer on the output channel
// (out_valid / out_stall) with the drive rate, direction and status flags.
// Configuration (cfg_valid / cfg_ready, cfg_index, cfg_wdata): index 0 is the
// acceleration limit, index 1 the tick rate; cfg_ready is always high. The user
// makes writes only while no command is in flight; the block does not check it.
// One command is processed at a time. Non-tick commands and ticks while
// stopped execute and then emit their status; running ticks without a move
// ramp the rate and update the travel sum before emitting. A tick during a
// move first multiplies the move total by the tick scale; unless the move
// completes or no distance remains, it then runs two more products, the
// stopping span and the squared rate, on the same shared 16-bit-digit
// multiplier. in_stall is high while a command is processed.
// The result register lets a new command be taken while the previous status
// waits; a stalled receiver holds the block in its final step until the
// status register frees up. Reset restores the acceleration limit to 256,
// the tick rate to 1000 and clears all motion state.
`default_nettype none

module stepper_ramp_position_profiler_core import srpp_pkg::*; #(
  parameter int FRAC_BITS  = 8,
  parameter int RATE_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [KIND_W-1:0]         in_kind,
  input  logic signed [DIST_W-1:0]  in_move_distance,
  input  logic signed [SPEED_W-1:0] in_speed_value,
  input  logic                      in_dir_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [DRIVE_W-1:0]        out_step_freq_hz,
  output logic                      out_dir_out,
  output logic                      out_is_running,
  output logic                      out_in_move,
  output logic                      out_move_done
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  srpp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  srpp_dp #(
    .FRAC_BITS  (FRAC_BITS),
    .RATE_WIDTH (RATE_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_kind          (in_kind),
    .in_move_distance (in_move_distance),
    .in_speed_value   (in_speed_value),
    .in_dir_value     (in_dir_value),
    .cmd              (cmd),
    .stat             (stat),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_step_freq_hz (out_step_freq_hz),
    .out_dir_out      (out_dir_out),
    .out_is_running   (out_is_running),
    .out_in_move      (out_in_move),
    .out_move_done    (out_move_done)
  );

endmodule

`default_nettype wire

/* hw/rtl/srpp_chk.sv */
`default_nettype none

module srpp_chk import srpp_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [DRIVE_W-1:0] out_step_freq_hz,
  input logic               out_is_running,
  input logic               out_in_move,
  input logic               out_move_done
);

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // A completing move reports a running, idle axis with no drive rate.
  a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_move_done |-> out_is_running && !out_in_move &&
                                   (out_step_freq_hz == '0))
    else $error("move completion reported with inconsistent status");

  // A move can only be in progress while the controller runs.
  a_move_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_in_move |-> out_is_running)
    else $error("move in progress while stopped");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_step_freq_hz) &&
                               $stable(out_move_done))
    else $error("stalled result changed");

endmodule

bind stepper_ramp_position_profiler_core srpp_chk u_srpp_chk (.*);

`default_nettype wire

/* verif/srpp_tb_pkg.sv */
`timescale 1ns / 100ps

package srpp_tb_pkg;
  import srpp_pkg::*;

  // Kinds 6 and 7 are legal on the port but carry no command.
  localparam logic [KIND_W-1:0]    KIND_SPARE_LO = 3'd6;
  localparam logic [KIND_W-1:0]    KIND_SPARE_HI = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE     = 2'd3;

  localparam int     PROFILE_FRAC    = 8;
  localparam longint RATE_HI         = 64'sd2147483647;
  localparam longint RATE_LO         = -RATE_HI - 1;
  localparam longint TRAVEL_HI       = (64'sd1 <<< 55) - 1;
  localparam longint TRAVEL_LO       = -TRAVEL_HI - 1;
  localparam int     MISMATCH_PRINTS = 10;

  typedef struct {
    logic [KIND_W-1:0]         kind;
    logic signed [DIST_W-1:0]  distance;
    logic signed [SPEED_W-1:0] speed;
    logic                      dir;
  } motion_cmd_t;

  typedef struct {
    logic [DRIVE_W-1:0] freq;
    logic               dir;
    logic               running;
    logic               moving;
    logic               done;
  } drive_status_t;

  class ramp_scoreboard;
    longint        accel_lim;
    longint        tick_hz;
    bit            running;
    bit            moving;
    bit            dir_q;
    longint        cur_rate;
    longint        tgt_rate;
    longint        dist_total;
    longint        travel;
    longint        drive;
    drive_status_t status_q[$];
    int            mismatches;
    int            checked;
    int            completions;

    function new();
      accel_lim   = longint'(ACCEL_RESET);
      tick_hz     = longint'(TICK_RESET);
      running     = 1'b0;
      moving      = 1'b0;
      dir_q       = 1'b0;
      cur_rate    = 0;
      tgt_rate    = 0;
      dist_total  = 0;
      travel      = 0;
      drive       = 0;
      mismatches  = 0;
      checked     = 0;
      completions = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_MAX_ACCEL) begin
        accel_lim = longint'(data[ACCEL_W-1:0]);
      end else if (idx == CFG_TICK_RATE) begin
        tick_hz = longint'(data[TICK_W-1:0]);
      end
    endfunction

    function longint sat_rate(longint v);
      if (v > RATE_HI) return RATE_HI;
      if (v < RATE_LO) return RATE_LO;
      return v;
    endfunction

    function void engage();
      if (running) return;
      cur_rate = sat_rate(accel_lim);
      tgt_rate = cur_rate;
      moving   = 1'b0;
      travel   = 0;
      running  = 1'b1;
    endfunction

    function drive_status_t advance(motion_cmd_t c);
      drive_status_t st;
      longint        steps;
      longint        speed;
      longint        scale;
      longint        rem;
      longint        diff;
      logic [63:0]   v_mag;
      logic [127:0]  v_sq;
      logic [127:0]  stop_span;
      bit            brake;
      bit            done;
      steps = longint'(c.distance);
      speed = sat_rate(longint'(c.speed));
      scale = ((tick_hz == 0) ? longint'(1) : tick_hz) << PROFILE_FRAC;
      done  = 1'b0;
      case (c.kind)
        KIND_START: engage();
        KIND_STOP: begin
          running  = 1'b0;
          moving   = 1'b0;
          cur_rate = 0;
          tgt_rate = 0;
          travel   = 0;
          drive    = 0;
        end
        KIND_MOVE: begin
          engage();
          moving     = 1'b1;
          dist_total = (steps < 0) ? -steps : steps;
          if (dist_total > longint'(TOTAL_MAX)) dist_total = longint'(TOTAL_MAX);
          travel     = 0;
          dir_q      = (steps < 0);
          tgt_rate   = speed;
        end
        KIND_SET_RATE: tgt_rate = speed;
        KIND_SET_DIR:  dir_q = c.dir;
        KIND_TICK: begin
          if (!running) begin
            cur_rate = 0;
            moving   = 1'b0;
          end else begin
            if (moving) begin
              // Remaining distance in travel units; brake once v^2 reaches 2*a*R.
              rem   = dist_total * scale - travel;
              brake = (rem <= 0);
              if (!brake) begin
                v_mag     = (cur_rate < 0) ? -cur_rate : cur_rate;
                v_sq      = {64'd0, v_mag} * {64'd0, v_mag};
                stop_span = {64'd0, 64'(2 * accel_lim)} * {64'd0, 64'(rem)};
                brake     = (stop_span <= v_sq);
              end
              if (brake) tgt_rate = 0;
              if (2 * rem <= scale) begin
                cur_rate = 0;
                tgt_rate = 0;
                moving   = 1'b0;
                drive    = 0;
                done     = 1'b1;
              end
            end
            if (!done) begin
              diff = tgt_rate - cur_rate;
              if (diff > accel_lim) cur_rate = cur_rate + accel_lim;
              else if (diff < -accel_lim) cur_rate = cur_rate - accel_lim;
              else cur_rate = tgt_rate;
              cur_rate = sat_rate(cur_rate);
              travel = travel + cur_rate;
              if (travel > TRAVEL_HI) travel = TRAVEL_HI;
              if (travel < TRAVEL_LO) travel = TRAVEL_LO;
              if (cur_rate > (longint'(1) <<< (PROFILE_FRAC - 1))) begin
                drive = cur_rate >>> PROFILE_FRAC;
                if (drive > longint'(DRIVE_MAX)) drive = longint'(DRIVE_MAX);
              end else begin
                drive = 0;
              end
            end
          end
        end
        default: ;
      endcase
      if (done) completions++;
      st.freq    = drive[DRIVE_W-1:0];
      st.dir     = dir_q;
      st.running = running;
      st.moving  = moving;
      st.done    = done;
      return st;
    endfunction

    function void note_cmd(motion_cmd_t c);
      status_q.push_back(advance(c));
    endfunction

    function void check_status(drive_status_t got);
      drive_status_t      want;
      logic [DRIVE_W-1:0] want_f[5];
      logic [DRIVE_W-1:0] got_f[5];
      string              field_names[5];
      int                 i;
      if (status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MISMATCH_PRINTS)
          $display("ERROR: status transfer with no command outstanding (freq %0d)", got.freq);
        return;
      end
      want = status_q.pop_front();
      checked++;
      field_names = '{"step_freq_hz", "dir_out", "is_running", "in_move", "move_done"};
      want_f = '{want.freq, want.dir, want.running, want.moving, want.done};
      got_f  = '{got.freq, got.dir, got.running, got.moving, got.done};
      for (i = 0; i < 5; i++) begin
        if (want_f[i] !== got_f[i]) begin
          mismatches++;
          if (mismatches <= MISMATCH_PRINTS)
            $display("ERROR: status %0d, %s expected %0d, got %0d",
                     checked, field_names[i], want_f[i], got_f[i]);
        end
      end
    endfunction

    function int pending();
      return status_q.size();
    endfunction
  endclass

endpackage

/* verif/tb.sv */
`timescale 1ns / 100ps

module tb;
  import srpp_pkg::*;
  import srpp_tb_pkg::*;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int MOVE_TICK_CAP  = 100;
  localparam int MOVE_TICKS_AIM = 40;
  localparam int PHASES         = 8;

  localparam int ACCEL_PLAN [PHASES] = '{64, 1024, 4096, 1, 16777215, 0, 300, 16777215};
  localparam int TICK_PLAN  [PHASES] = '{1, 4, 100, 1, 1048575, 0, 0, 1};
  localparam int ITEM_PLAN  [PHASES] = '{300, 300, 250, 150, 250, 100, 150, 150};

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_wdata;
  logic                      in_valid;
  logic                      in_stall;
  logic [KIND_W-1:0]         in_kind;
  logic signed [DIST_W-1:0]  in_move_distance;
  logic signed [SPEED_W-1:0] in_speed_value;
  logic                      in_dir_value;
  logic                      out_valid;
  logic                      out_stall;
  logic [DRIVE_W-1:0]        out_step_freq_hz;
  logic                      out_dir_out;
  logic                      out_is_running;
  logic                      out_in_move;
  logic                      out_move_done;

  ramp_scoreboard sb;
  int             items_left = 0;
  int             items_sent = 0;
  int             cycles     = 0;
  bit             in_quiet   = 1'b0;
  bit             out_quiet  = 1'b0;

  stepper_ramp_position_profiler_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_move_distance (in_move_distance),
    .in_speed_value   (in_speed_value),
    .in_dir_value     (in_dir_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_step_freq_hz (out_step_freq_hz),
    .out_dir_out      (out_dir_out),
    .out_is_running   (out_is_running),
    .out_in_move      (out_in_move),
    .out_move_done    (out_move_done)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("ERROR: run did not finish within %0d cycles", CYCLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // Status side: check every transfer, then hold off for a random number of cycles.
  initial begin
    drive_status_t seen;
    int            hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        seen.freq    = out_step_freq_hz;
        seen.dir     = out_dir_out;
        seen.running = out_is_running;
        seen.moving  = out_in_move;
        seen.done    = out_move_done;
        sb.check_status(seen);
        hold_left = out_quiet ? 0 : int'($urandom_range(0, 4));
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic motion_cmd_t make_cmd(logic [KIND_W-1:0] k, longint d, longint s,
                                           logic dr);
    motion_cmd_t c;
    c.kind     = k;
    c.distance = d[DIST_W-1:0];
    c.speed    = s[SPEED_W-1:0];
    c.dir      = dr;
    return c;
  endfunction

  // Fields that the kind does not use still carry random bits.
  function automatic motion_cmd_t filler_cmd(logic [KIND_W-1:0] k);
    return make_cmd(k, longint'($urandom), longint'($urandom), 1'($urandom_range(0, 1)));
  endfunction

  function automatic motion_cmd_t noise_cmd();
    return make_cmd(KIND_W'($urandom_range(0, 7)), longint'($urandom), longint'($urandom),
                    1'($urandom_range(0, 1)));
  endfunction

  // Called right after a rising edge; returns at the edge of the transfer.
  task automatic send(input motion_cmd_t c);
    int gap;
    gap = in_quiet ? 0 : int'($urandom_range(0, 4));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_kind          <= c.kind;
    in_move_distance <= c.distance;
    in_speed_value   <= c.speed;
    in_dir_value     <= c.dir;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_cmd(c);
    items_sent++;
    if (c.kind <= KIND_SET_DIR) items_left--;
  endtask

  task automatic load_regs(input logic [CFG_DATA_W-1:0] accel,
                           input logic [CFG_DATA_W-1:0] tick, input bit with_spare);
    logic [CFG_DATA_W-1:0] junk;
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_MAX_ACCEL;
    cfg_wdata <= accel;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.write_reg(CFG_MAX_ACCEL, accel);
    cfg_index <= CFG_TICK_RATE;
    cfg_wdata <= tick;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.write_reg(CFG_TICK_RATE, tick);
    if (with_spare) begin
      junk = CFG_DATA_W'($urandom);
      cfg_index <= CFG_SPARE;
      cfg_wdata <= junk;
      do @(posedge clk); while (cfg_ready !== 1'b1);
      sb.write_reg(CFG_SPARE, junk);
    end
    cfg_valid <= 1'b0;
  endtask

  // A move sized so that it usually finishes within a few dozen ticks.
  task automatic run_move();
    longint spd;
    longint scale;
    longint span;
    longint steps;
    int     n;
    scale = ((sb.tick_hz == 0) ? longint'(1) : sb.tick_hz) << PROFILE_FRAC;
    if (sb.accel_lim == 0) spd = longint'($urandom_range(1, 65536));
    else spd = sb.accel_lim * longint'($urandom_range(1, 12));
    if (spd > RATE_HI) spd = RATE_HI;
    case ($urandom_range(0, 19))
      0, 1: spd = -spd;
      2: spd = longint'($urandom);
      default: ;
    endcase
    span = MOVE_TICKS_AIM * ((spd < 0) ? -spd : spd) / scale + 1;
    if (span > longint'(TOTAL_MAX)) span = longint'(TOTAL_MAX);
    steps = longint'($urandom_range(0, 32'(span)));
    if ($urandom_range(0, 1)) steps = -steps;
    send(make_cmd(KIND_MOVE, steps, spd, 1'($urandom_range(0, 1))));
    n = 0;
    while (sb.moving && n < MOVE_TICK_CAP && items_left > 0) begin
      if ($urandom_range(0, 11) == 0) send(noise_cmd());
      else send(filler_cmd(KIND_TICK));
      n++;
    end
    repeat ($urandom_range(0, 2)) send(filler_cmd(KIND_TICK));
    if ($urandom_range(0, 3) == 0) send(filler_cmd(KIND_STOP));
  endtask

  task automatic free_run();
    longint spd;
    spd = sb.accel_lim * longint'($urandom_range(0, 8));
    if ($urandom_range(0, 2) == 0) spd = -spd;
    if (!sb.running || $urandom_range(0, 3) == 0) send(filler_cmd(KIND_START));
    send(make_cmd(KIND_SET_RATE, longint'($urandom), spd, 1'($urandom_range(0, 1))));
    repeat ($urandom_range(1, 10)) send(filler_cmd(KIND_TICK));
  endtask

  initial begin
    int ph;
    int pick;
    sb = new();
    rst_n            <= 1'b0;
    cfg_valid        <= 1'b0;
    cfg_index        <= CFG_MAX_ACCEL;
    cfg_wdata        <= '0;
    in_valid         <= 1'b0;
    in_kind          <= KIND_TICK;
    in_move_distance <= '0;
    in_speed_value   <= '0;
    in_dir_value     <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset settings.
    send(filler_cmd(KIND_TICK));
    send(make_cmd(KIND_SET_DIR, longint'($urandom), longint'($urandom), 1'b1));
    send(make_cmd(KIND_SET_DIR, longint'($urandom), longint'($urandom), 1'b0));
    send(make_cmd(KIND_SET_RATE, longint'($urandom), RATE_HI, 1'b1));
    send(make_cmd(KIND_SET_RATE, longint'($urandom), RATE_LO, 1'b0));
    send(filler_cmd(KIND_START));
    send(filler_cmd(KIND_START));
    send(make_cmd(KIND_SET_RATE, longint'($urandom), 64'sd1000, 1'b0));
    repeat (3) send(filler_cmd(KIND_TICK));
    send(make_cmd(KIND_SET_RATE, longint'($urandom), -64'sd2000, 1'b1));
    repeat (2) send(filler_cmd(KIND_TICK));
    send(filler_cmd(KIND_SPARE_LO));
    send(filler_cmd(KIND_SPARE_HI));
    send(filler_cmd(KIND_STOP));
    send(make_cmd(KIND_MOVE, -64'sd8388608, RATE_HI, 1'b0));
    send(filler_cmd(KIND_TICK));
    send(make_cmd(KIND_MOVE, 64'sd8388607, 64'sd0, 1'b1));
    send(filler_cmd(KIND_TICK));
    send(make_cmd(KIND_MOVE, 64'sd0, 64'sd4096, 1'b0));
    repeat (2) send(filler_cmd(KIND_TICK));
    send(filler_cmd(KIND_STOP));
    send(filler_cmd(KIND_TICK));

    for (ph = 0; ph < PHASES; ph++) begin
      load_regs(CFG_DATA_W'(ACCEL_PLAN[ph]), CFG_DATA_W'(TICK_PLAN[ph]), ph == 0);
      items_left = ITEM_PLAN[ph];
      while (items_left > 0) begin
        in_quiet  = ($urandom_range(0, 5) == 0);
        out_quiet = ($urandom_range(0, 5) == 0);
        pick = int'($urandom_range(0, 99));
        if (pick < 70) begin
          run_move();
        end else if (pick < 85) begin
          free_run();
        end else begin
          repeat ($urandom_range(1, 5)) send(noise_cmd());
        end
      end
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d commands across %0d register settings, %0d status transfers checked.",
             items_sent, PHASES + 1, sb.checked);
    $display("Moves run to completion: %0d, mismatches: %0d.", sb.completions, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* stepper_ramp_position_profiler_core.f */
hw/rtl/srpp_pkg.sv
hw/rtl/srpp_mul.sv
hw/rtl/srpp_dp.sv
hw/rtl/srpp_ctrl.sv
hw/rtl/stepper_ramp_position_profiler_core.sv
hw/rtl/srpp_chk.sv
verif/srpp_tb_pkg.sv
verif/tb.sv
